### src/s2l_pkg.sv
package s2l_pkg;

    // Input operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BEFORE = 2'd1;
    localparam logic [1:0] STAT_BEYOND = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_YEARS_IN_TABLE  = 3'd0;
    localparam logic [2:0] CFG_EPOCH_YEAR      = 3'd1;
    localparam logic [2:0] CFG_EPOCH_MONTH     = 3'd2;
    localparam logic [2:0] CFG_EPOCH_DAY       = 3'd3;
    localparam logic [2:0] CFG_BASE_LUNAR_YEAR = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    // Configuration reset values
    localparam logic [8:0]  RST_YEARS_IN_TABLE  = 9'd200;
    localparam logic [13:0] RST_EPOCH_YEAR      = 14'd1900;
    localparam logic [3:0]  RST_EPOCH_MONTH     = 4'd1;
    localparam logic [4:0]  RST_EPOCH_DAY       = 5'd31;
    localparam logic [13:0] RST_BASE_LUNAR_YEAR = 14'd1900;

    localparam int WORD_W = 20;

    // Day offset from the epoch, signed; the magnitude part holds walk values
    localparam int OFFS_W = 24;
    localparam int MAG_W  = OFFS_W - 1;

    localparam logic [4:0] LEN_SHORT = 5'd29;
    localparam logic [4:0] LEN_LONG  = 5'd30;
    localparam logic [8:0] YEAR12_BASE = 9'd348;   // 12 months of 29 days
    localparam logic [8:0] YEAR13_BASE = 9'd377;   // 13 months of 29 days
    localparam logic [17:0] DAYS_PER_ERA = 18'd146097;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERA,
        ST_DOY,
        ST_DOE,
        ST_OFFS,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic tbl_write;
        logic era_en;
        logic doy_en;
        logic doe_en;
        logic offs_en;
        logic year_scan;
        logic year_step;
        logic year_hit;
        logic month_step;
        logic set_before;
        logic set_beyond;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic offs_neg;
        logic year_end;
        logic year_hit;
        logic month_done;
    } dp_stat_t;

    // 400-year era of a date; January and February count to the year before.
    // floor(y / 400) = floor(floor(y / 16) / 25), and x * 41 >> 10 is exact
    // for x below 1024.
    function automatic logic signed [6:0] era_of(input logic [13:0] y,
                                                 input logic [3:0] m);
        logic [13:0] ya;
        logic [15:0] p;
        ya = (m <= 4'd2) ? y - 14'd1 : y;
        p  = 16'(ya[13:4]) * 16'd41;
        if ((m <= 4'd2) && (y == 14'd0))
            return -7'sd1;
        return $signed({1'b0, p[15:10]});
    endfunction

    // Year within the era, 0 to 399
    function automatic logic [8:0] yoe_of(input logic [13:0] y,
                                          input logic [3:0] m,
                                          input logic signed [6:0] era);
        logic [13:0] ya;
        logic [13:0] r;
        ya = (m <= 4'd2) ? y - 14'd1 : y;
        r  = ya - 14'(era[5:0]) * 14'd400;
        if (era[6])
            return 9'd399;
        return r[8:0];
    endfunction

    // Day of the March-based year; may reach -1 for a zero day
    function automatic logic signed [9:0] doy_of(input logic [3:0] m,
                                                 input logic [4:0] d);
        logic [3:0] mp;
        logic [8:0] b;
        mp = (m > 4'd2) ? m - 4'd3 : m + 4'd9;
        case (mp)
            4'd0:    b = 9'd0;
            4'd1:    b = 9'd31;
            4'd2:    b = 9'd61;
            4'd3:    b = 9'd92;
            4'd4:    b = 9'd122;
            4'd5:    b = 9'd153;
            4'd6:    b = 9'd184;
            4'd7:    b = 9'd214;
            4'd8:    b = 9'd245;
            4'd9:    b = 9'd275;
            4'd10:   b = 9'd306;
            4'd11:   b = 9'd337;
            4'd12:   b = 9'd367;
            default: b = 9'd0;
        endcase
        return $signed({1'b0, b}) + $signed({5'b0, d}) - 10'sd1;
    endfunction

    // Day of the era: yoe*365 + yoe/4 - yoe/100 + doy
    function automatic logic signed [18:0] doe_of(input logic [8:0] yoe,
                                                  input logic signed [9:0] doy);
        logic [17:0] y365;
        logic [11:0] p;
        y365 = 18'(yoe) * 18'd365;
        p    = 12'(yoe[8:2]) * 12'd41;
        return $signed({1'b0, y365}) + $signed({12'b0, yoe[8:2]})
             - $signed({17'b0, p[11:10]}) + 19'(doy);
    endfunction

endpackage

### src/s2l_ram.sv
module s2l_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/s2l_ctrl.sv
module s2l_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                operation,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  s2l_pkg::dp_stat_t   stat,
    output s2l_pkg::ctrl_cmd_t  cmd
);

    s2l_pkg::state_t state_reg;
    s2l_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= s2l_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        case (state_reg)
            s2l_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (operation == s2l_pkg::OP_LOAD)
                    begin
                        cmd.tbl_write = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = s2l_pkg::ST_ERA;
                    end
                end
            end
            s2l_pkg::ST_ERA:
            begin
                cmd.era_en = 1'b1;
                state_next = s2l_pkg::ST_DOY;
            end
            s2l_pkg::ST_DOY:
            begin
                cmd.doy_en = 1'b1;
                state_next = s2l_pkg::ST_DOE;
            end
            s2l_pkg::ST_DOE:
            begin
                cmd.doe_en = 1'b1;
                state_next = s2l_pkg::ST_OFFS;
            end
            s2l_pkg::ST_OFFS:
            begin
                // table entry zero is read here, ready for the year walk
                cmd.offs_en = 1'b1;
                if (stat.offs_neg)
                begin
                    cmd.set_before = 1'b1;
                    state_next     = s2l_pkg::ST_DONE;
                end
                else
                begin
                    state_next = s2l_pkg::ST_YEAR;
                end
            end
            s2l_pkg::ST_YEAR:
            begin
                cmd.year_scan = 1'b1;
                if (stat.year_end)
                begin
                    cmd.set_beyond = 1'b1;
                    state_next     = s2l_pkg::ST_DONE;
                end
                else if (stat.year_hit)
                begin
                    cmd.year_hit = 1'b1;
                    state_next   = s2l_pkg::ST_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            s2l_pkg::ST_MONTH:
            begin
                if (stat.month_done)
                begin
                    state_next = s2l_pkg::ST_DONE;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            s2l_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = s2l_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = s2l_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

endmodule

### src/s2l_dp.sv
module s2l_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  s2l_pkg::ctrl_cmd_t               cmd,
    output s2l_pkg::dp_stat_t                stat,
    input  logic                             cfg_we,
    input  logic [s2l_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [s2l_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [7:0]                       table_index,
    input  logic [19:0]                      table_word,
    input  logic [13:0]                      solar_year,
    input  logic [3:0]                       solar_month,
    input  logic [4:0]                       solar_day,
    output logic [1:0]                       status,
    output logic [13:0]                      lunar_year,
    output logic [3:0]                       lunar_month,
    output logic [4:0]                       lunar_day,
    output logic                             leap_month_flag
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int LW  = (CW > 9) ? CW : 9;
    localparam int IXW = (AW > 8) ? AW : 8;

    // configuration
    logic [8:0]  years_reg;
    logic [13:0] ep_year_reg;
    logic [3:0]  ep_month_reg;
    logic [4:0]  ep_day_reg;
    logic [13:0] base_reg;

    // captured date
    logic [13:0] sy_reg;
    logic [3:0]  sm_reg;
    logic [4:0]  sd_reg;

    // civil day stages, solar and epoch side by side
    logic signed [6:0]  era_s_reg;
    logic signed [6:0]  era_e_reg;
    logic [8:0]         yoe_s_reg;
    logic [8:0]         yoe_e_reg;
    logic signed [9:0]  doy_s_reg;
    logic signed [9:0]  doy_e_reg;
    logic signed [18:0] doe_s_reg;
    logic signed [18:0] doe_e_reg;

    logic signed [s2l_pkg::OFFS_W-1:0] offs_reg;
    logic signed [s2l_pkg::OFFS_W-1:0] offs_next;
    logic signed [7:0]                 era_diff;
    logic [s2l_pkg::MAG_W-1:0]         offs_mag;

    // walk state
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_inc;
    logic [3:0]    mi_reg;
    logic [15:0]   mbits_reg;
    logic [3:0]    lm_reg;
    logic          has_leap_reg;
    logic [1:0]    stat_reg;

    // table
    logic [IXW-1:0]               tidx_ext;
    logic                         wr_en;
    logic [AW-1:0]                rd_addr;
    logic [s2l_pkg::WORD_W-1:0]   rd_word;
    logic [3:0]                   rd_lm;
    logic                         rd_has_leap;
    logic [8:0]                   year_total;
    logic [LW-1:0]                limit;

    // month walk and result
    logic [3:0] n_cur;
    logic [4:0] mlen;
    logic [3:0] res_month;
    logic       res_leap;

    // output register
    logic [1:0]  status_reg;
    logic [13:0] lyear_reg;
    logic [3:0]  lmonth_reg;
    logic [4:0]  lday_reg;
    logic        lflag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            years_reg    <= s2l_pkg::RST_YEARS_IN_TABLE;
            ep_year_reg  <= s2l_pkg::RST_EPOCH_YEAR;
            ep_month_reg <= s2l_pkg::RST_EPOCH_MONTH;
            ep_day_reg   <= s2l_pkg::RST_EPOCH_DAY;
            base_reg     <= s2l_pkg::RST_BASE_LUNAR_YEAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                s2l_pkg::CFG_YEARS_IN_TABLE:  years_reg    <= cfg_data[8:0];
                s2l_pkg::CFG_EPOCH_YEAR:      ep_year_reg  <= cfg_data;
                s2l_pkg::CFG_EPOCH_MONTH:     ep_month_reg <= cfg_data[3:0];
                s2l_pkg::CFG_EPOCH_DAY:       ep_day_reg   <= cfg_data[4:0];
                s2l_pkg::CFG_BASE_LUNAR_YEAR: base_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // load items beyond the table depth are dropped
    assign tidx_ext = IXW'(table_index);
    assign wr_en    = cmd.tbl_write && (32'(table_index) < TABLE_DEPTH);
    assign idx_inc  = idx_reg + 1'b1;
    assign rd_addr  = cmd.year_scan ? idx_inc[AW-1:0] : '0;

    s2l_ram #(
        .WIDTH (s2l_pkg::WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (tidx_ext[AW-1:0]),
        .wdata (table_word),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    // a leap number of 1..12 adds a thirteenth month in bit order
    assign rd_lm       = rd_word[19:16];
    assign rd_has_leap = (rd_lm != 4'd0) && (rd_lm <= 4'd12);
    assign year_total  = rd_has_leap
                       ? s2l_pkg::YEAR13_BASE + 9'($countones(rd_word[12:0]))
                       : s2l_pkg::YEAR12_BASE + 9'($countones(rd_word[11:0]));

    assign limit = (LW'(years_reg) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(years_reg);

    assign era_diff  = 8'(era_s_reg) - 8'(era_e_reg);
    assign offs_next = $signed(s2l_pkg::OFFS_W'(era_diff))
                     * $signed(s2l_pkg::OFFS_W'(s2l_pkg::DAYS_PER_ERA))
                     + s2l_pkg::OFFS_W'(doe_s_reg) - s2l_pkg::OFFS_W'(doe_e_reg);
    assign offs_mag  = offs_reg[s2l_pkg::MAG_W-1:0];

    assign n_cur = has_leap_reg ? 4'd13 : 4'd12;
    assign mlen  = mbits_reg[mi_reg] ? s2l_pkg::LEN_LONG : s2l_pkg::LEN_SHORT;

    assign stat.offs_neg   = offs_next[s2l_pkg::OFFS_W-1];
    assign stat.year_end   = LW'(idx_reg) >= limit;
    assign stat.year_hit   = offs_mag < s2l_pkg::MAG_W'(year_total);
    assign stat.month_done = !((mi_reg < n_cur) && (offs_mag >= s2l_pkg::MAG_W'(mlen)));

    always_comb
    begin
        res_leap  = 1'b0;
        res_month = mi_reg + 4'd1;
        if (has_leap_reg && (mi_reg == lm_reg))
        begin
            res_month = lm_reg;
            res_leap  = 1'b1;
        end
        else if (has_leap_reg && (mi_reg > lm_reg))
        begin
            res_month = mi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sy_reg   <= solar_year;
            sm_reg   <= solar_month;
            sd_reg   <= solar_day;
            idx_reg  <= '0;
            mi_reg   <= 4'd0;
            stat_reg <= s2l_pkg::STAT_OK;
        end
        if (cmd.era_en)
        begin
            era_s_reg <= s2l_pkg::era_of(sy_reg, sm_reg);
            era_e_reg <= s2l_pkg::era_of(ep_year_reg, ep_month_reg);
        end
        if (cmd.doy_en)
        begin
            yoe_s_reg <= s2l_pkg::yoe_of(sy_reg, sm_reg, era_s_reg);
            yoe_e_reg <= s2l_pkg::yoe_of(ep_year_reg, ep_month_reg, era_e_reg);
            doy_s_reg <= s2l_pkg::doy_of(sm_reg, sd_reg);
            doy_e_reg <= s2l_pkg::doy_of(ep_month_reg, ep_day_reg);
        end
        if (cmd.doe_en)
        begin
            doe_s_reg <= s2l_pkg::doe_of(yoe_s_reg, doy_s_reg);
            doe_e_reg <= s2l_pkg::doe_of(yoe_e_reg, doy_e_reg);
        end
        if (cmd.offs_en)
        begin
            offs_reg <= offs_next;
        end
        if (cmd.year_step)
        begin
            offs_reg <= offs_reg - s2l_pkg::OFFS_W'(year_total);
            idx_reg  <= idx_inc;
        end
        if (cmd.year_hit)
        begin
            mbits_reg    <= {3'b0, rd_word[12:0]};
            lm_reg       <= rd_lm;
            has_leap_reg <= rd_has_leap;
        end
        if (cmd.month_step)
        begin
            offs_reg <= offs_reg - s2l_pkg::OFFS_W'(mlen);
            mi_reg   <= mi_reg + 4'd1;
        end
        if (cmd.set_before)
        begin
            stat_reg <= s2l_pkg::STAT_BEFORE;
        end
        if (cmd.set_beyond)
        begin
            stat_reg <= s2l_pkg::STAT_BEYOND;
        end
        if (cmd.out_load)
        begin
            status_reg <= stat_reg;
            if (stat_reg == s2l_pkg::STAT_OK)
            begin
                lyear_reg  <= 14'(base_reg + 14'(idx_reg));
                lmonth_reg <= res_month;
                lday_reg   <= 5'(offs_reg[4:0] + 5'd1);
                lflag_reg  <= res_leap;
            end
            else
            begin
                lyear_reg  <= 14'd0;
                lmonth_reg <= 4'd0;
                lday_reg   <= 5'd0;
                lflag_reg  <= 1'b0;
            end
        end
    end

    assign status          = status_reg;
    assign lunar_year      = lyear_reg;
    assign lunar_month     = lmonth_reg;
    assign lunar_day       = lday_reg;
    assign leap_month_flag = lflag_reg;

endmodule

### src/solar_to_lunar_date_top.sv
// Gregorian to Chinese lunar date converter.
// Input channel (in_valid / in_stall): a word is either a load, which writes
// table_word into year table entry table_index and gives no result, or a
// convert of solar_year / solar_month / solar_day, which gives one result.
// Output channel (out_valid / out_stall): status, lunar_year, lunar_month,
// lunar_day, leap_month_flag; on an error status the date fields are zero.
// A load is taken while idle and leaves the controller idle. A convert runs
// the day-count arithmetic (ERA, DOY, DOE, OFFS states), then walks the
// table years (YEAR state, one table memory read per cycle) to the year it
// lands in, then the months (MONTH state, up to 12 walked), then loads the
// output register (DONE state). A date before the epoch goes from OFFS to
// DONE; a date past the table end walks years_in_table (at most the depth).
// in_stall is high while a convert is in progress; the next word is taken
// the cycle after the result is loaded. Configuration (cfg_we / cfg_index /
// cfg_data) is to be written only while idle; the block leaves it unchecked.
// Reset clears the controller and the output valid and restores the
// configuration defaults; table entries are undefined until loaded.
// While out_stall holds a result, the next convert runs to completion and
// then waits; loads are still taken until a convert is accepted.
module solar_to_lunar_date_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [7:0]                       table_index,
    input  logic [19:0]                      table_word,
    input  logic [13:0]                      solar_year,
    input  logic [3:0]                       solar_month,
    input  logic [4:0]                       solar_day,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [13:0]                      lunar_year,
    output logic [3:0]                       lunar_month,
    output logic [4:0]                       lunar_day,
    output logic                             leap_month_flag,
    input  logic                             cfg_we,
    input  logic [s2l_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [s2l_pkg::CFG_DATA_W-1:0]   cfg_data
);

    s2l_pkg::ctrl_cmd_t cmd;
    s2l_pkg::dp_stat_t  stat;

    s2l_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    s2l_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .table_index     (table_index),
        .table_word      (table_word),
        .solar_year      (solar_year),
        .solar_month     (solar_month),
        .solar_day       (solar_day),
        .status          (status),
        .lunar_year      (lunar_year),
        .lunar_month     (lunar_month),
        .lunar_day       (lunar_day),
        .leap_month_flag (leap_month_flag)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int TBL_DEPTH   = 256;
    localparam int QUIET_LIMIT = 5000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        leap;
    } lunar_date_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            operation;
    logic [7:0]                      table_index;
    logic [19:0]                     table_word;
    logic [13:0]                     solar_year;
    logic [3:0]                      solar_month;
    logic [4:0]                      solar_day;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      status;
    logic [13:0]                     lunar_year;
    logic [3:0]                      lunar_month;
    logic [4:0]                      lunar_day;
    logic                            leap_month_flag;
    logic                            cfg_we;
    logic [s2l_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [s2l_pkg::CFG_DATA_W-1:0]  cfg_data;

    // predictor copy of the year table and the registers
    logic [19:0] year_tbl [TBL_DEPTH];
    logic [8:0]  years_cfg;
    logic [13:0] epoch_y_cfg;
    logic [3:0]  epoch_m_cfg;
    logic [4:0]  epoch_d_cfg;
    logic [13:0] base_cfg;

    lunar_date_t pending_dates[$];

    int errors       = 0;
    int n_loads      = 0;
    int n_in_table   = 0;
    int n_before     = 0;
    int n_beyond     = 0;
    int n_settings   = 0;
    int quiet_cycles = 0;
    int in_gap_pct;
    int out_stall_pct;

    always #5 clk = ~clk;

    solar_to_lunar_date_top #(.TABLE_DEPTH(TBL_DEPTH)) u_dut (.*);

    // Day count from 1970-01-01 in the civil calendar, floor division for negative years
    function automatic longint day_number(longint y, longint m, longint d);
        longint era, yoe, doy, doe;
        if (m <= 2)
            y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic longint epoch_day_number();
        return day_number(epoch_y_cfg, epoch_m_cfg, epoch_d_cfg);
    endfunction

    function automatic int months_in(logic [19:0] w);
        return (w[19:16] != 4'd0 && w[19:16] <= 4'd12) ? 13 : 12;
    endfunction

    // month p in calendar order (leap month included) uses length bit p
    function automatic int year_length(logic [19:0] w);
        int total;
        total = 0;
        for (int p = 0; p < months_in(w); p++)
            total += w[p] ? 30 : 29;
        return total;
    endfunction

    function automatic int walk_limit();
        return (years_cfg > TBL_DEPTH) ? TBL_DEPTH : int'(years_cfg);
    endfunction

    function automatic longint year_start(int k);
        longint total;
        total = 0;
        for (int i = 0; i < k; i++)
            total += year_length(year_tbl[i]);
        return total;
    endfunction

    function automatic lunar_date_t lunar_of(logic [13:0] y, logic [3:0] m, logic [4:0] d);
        lunar_date_t r;
        longint      rest;
        int          yi, p;
        logic [19:0] w;
        r    = '0;
        rest = day_number(y, m, d) - epoch_day_number();
        if (rest < 0)
        begin
            r.status = s2l_pkg::STAT_BEFORE;
            return r;
        end
        yi = 0;
        while (yi < walk_limit() && rest >= year_length(year_tbl[yi]))
        begin
            rest -= year_length(year_tbl[yi]);
            yi++;
        end
        if (yi >= walk_limit())
        begin
            r.status = s2l_pkg::STAT_BEYOND;
            return r;
        end
        w = year_tbl[yi];
        p = 0;
        while (rest >= (w[p] ? 30 : 29))
        begin
            rest -= w[p] ? 30 : 29;
            p++;
        end
        r.status = s2l_pkg::STAT_OK;
        r.year   = base_cfg + 14'(yi);
        if (months_in(w) == 13 && p == w[19:16])
        begin
            r.month = w[19:16];
            r.leap  = 1'b1;
        end
        else if (months_in(w) == 13 && p > w[19:16])
            r.month = 4'(p);
        else
            r.month = 4'(p + 1);
        r.day = 5'(rest + 1);
        return r;
    endfunction

    // Gregorian date n days after the epoch new year, clamped to years 0..9999
    function automatic void date_after(longint n, output logic [13:0] y,
                                       output logic [3:0] m, output logic [4:0] d);
        longint z, era, doe, yoe, doy, mp, dd, mm, yy;
        z   = epoch_day_number() + n + 719468;
        era = (z >= 0 ? z : z - 146096) / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        dd  = doy - (153 * mp + 2) / 5 + 1;
        mm  = mp < 10 ? mp + 3 : mp - 9;
        yy  = yoe + era * 400 + (mm <= 2 ? 1 : 0);
        if (yy < 0)
        begin
            y = 14'd0;
            m = 4'd1;
            d = 5'd1;
        end
        else if (yy > 9999)
        begin
            y = 14'd9999;
            m = 4'd12;
            d = 5'd31;
        end
        else
        begin
            y = 14'(yy);
            m = 4'(mm);
            d = 5'(dd);
        end
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic send_word(logic op, logic [7:0] idx, logic [19:0] word,
                             logic [13:0] y, logic [3:0] m, logic [4:0] d);
        @(negedge clk);
        while ($urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        table_index <= idx;
        table_word  <= word;
        solar_year  <= y;
        solar_month <= m;
        solar_day   <= d;
        do
            @(posedge clk);
        while (in_stall);
        if (op == s2l_pkg::OP_LOAD)
        begin
            year_tbl[idx] = word;
            n_loads++;
        end
        else
            pending_dates.push_back(lunar_of(y, m, d));
    endtask

    task automatic send_convert(logic [13:0] y, logic [3:0] m, logic [4:0] d);
        send_word(s2l_pkg::OP_CONVERT, 8'($urandom), 20'($urandom), y, m, d);
    endtask

    task automatic send_load(logic [7:0] idx, logic [19:0] word);
        send_word(s2l_pkg::OP_LOAD, idx, word, 14'($urandom_range(9999)),
                  4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)));
    endtask

    task automatic send_days_after(longint n);
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        date_after(n, y, m, d);
        send_convert(y, m, d);
    endtask

    // drop valid, drain every result, then let a trailing load settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(negedge clk);
        repeat (32) @(negedge clk);
    endtask

    task automatic write_reg(logic [s2l_pkg::CFG_INDEX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= s2l_pkg::CFG_DATA_W'(val);
        case (idx)
            s2l_pkg::CFG_YEARS_IN_TABLE:  years_cfg   = 9'(val);
            s2l_pkg::CFG_EPOCH_YEAR:      epoch_y_cfg = 14'(val);
            s2l_pkg::CFG_EPOCH_MONTH:     epoch_m_cfg = 4'(val);
            s2l_pkg::CFG_EPOCH_DAY:       epoch_d_cfg = 5'(val);
            s2l_pkg::CFG_BASE_LUNAR_YEAR: base_cfg    = 14'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int unsigned yrs, int unsigned ey, int unsigned em,
                              int unsigned ed, int unsigned base);
        wait_idle();
        write_reg(s2l_pkg::CFG_YEARS_IN_TABLE, yrs);
        write_reg(s2l_pkg::CFG_EPOCH_YEAR, ey);
        write_reg(s2l_pkg::CFG_EPOCH_MONTH, em);
        write_reg(s2l_pkg::CFG_EPOCH_DAY, ed);
        write_reg(s2l_pkg::CFG_BASE_LUNAR_YEAR, base);
        n_settings++;
    endtask

    // epoch day, day before it, start of the second year, both ends of the walk
    task automatic check_edges();
        send_days_after(0);
        send_days_after(-1);
        send_days_after(year_start(1));
        send_days_after(year_start(walk_limit()) - 1);
        send_days_after(year_start(walk_limit()));
    endtask

    task automatic test_table_fill();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        send_load(8'd0, 20'h00000);  // twelve short months, no leap
        send_load(8'd1, 20'hF1FFF);  // leap number above twelve: plain year of long months
        send_load(8'd2, 20'hCFFFF);  // leap month after the twelfth
        send_load(8'd3, 20'h1AAAA);  // leap month after the first
        for (int i = 4; i < TBL_DEPTH; i++)
            send_load(8'(i), 20'($urandom));
    endtask

    task automatic test_directed_dates();
        check_edges();
        send_convert(14'd0, 4'd1, 5'd1);
        send_convert(14'd9999, 4'd12, 5'd31);
        send_days_after(year_start(2) + 12 * 30);
        send_days_after(year_start(3) + 29 + 3);
        // a leap day and days that do not exist are run through the day-count formula as they are
        send_convert(14'd2000, 4'd2, 5'd29);
        send_convert(14'd1999, 4'd2, 5'd30);
        send_convert(14'd2021, 4'd2, 5'd31);
        send_convert(14'd2020, 4'd4, 5'd31);
        // overwrite the first year, then land in its leap month
        send_load(8'd0, 20'h30FFF);
        send_days_after(3 * 30 + 5);
    endtask

    task automatic test_register_extremes();
        set_config(0, 1900, 1, 31, 1900);
        send_days_after(0);
        send_days_after(-1);
        send_days_after(500);
        set_config(256, 1, 1, 1, 0);
        check_edges();
        set_config(511, 9999, 12, 31, 9999);
        send_days_after(0);
        send_days_after(-1);
        // lunar year number wraps past entry zero
        set_config(511, 2, 3, 1, 16383);
        check_edges();
    endtask

    task automatic test_random_traffic();
        int     gap_pct[4]   = '{0, 51, 0, 15};
        int     stall_pct[4] = '{0, 0, 51, 15};
        int     yrs;
        int     k;
        longint span;
        for (int phase = 0; phase < 4; phase++)
        begin
            case ($urandom_range(3))
                0:       yrs = $urandom_range(1, 40);
                1:       yrs = 200;
                2:       yrs = 256;
                default: yrs = $urandom_range(257, 511);
            endcase
            set_config(yrs, $urandom_range(1, 9000), $urandom_range(1, 12),
                       $urandom_range(1, 31), $urandom_range(0, 16383));
            in_gap_pct    = gap_pct[phase];
            out_stall_pct = stall_pct[phase];
            repeat (300)
            begin
                k = $urandom_range(99);
                if (k < 12)
                    send_load(8'($urandom), 20'($urandom));
                else if (k < 22)
                    send_days_after(-longint'($urandom_range(1, 800)));
                else if (k < 32)
                    send_convert(14'($urandom_range(9999)), 4'($urandom_range(1, 12)),
                                 5'($urandom_range(1, 31)));
                else
                begin
                    span = year_start(walk_limit());
                    send_days_after($urandom_range(0, 32'(span) + 40));
                end
            end
        end
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    always @(posedge clk)
    begin
        lunar_date_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_dates.size() == 0)
                report_mismatch($sformatf("result with nothing pending, status %0d", status));
            else
            begin
                want = pending_dates.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (lunar_year !== want.year)
                    report_mismatch($sformatf("lunar_year %0d, want %0d",
                                              lunar_year, want.year));
                if (lunar_month !== want.month)
                    report_mismatch($sformatf("lunar_month %0d, want %0d",
                                              lunar_month, want.month));
                if (lunar_day !== want.day)
                    report_mismatch($sformatf("lunar_day %0d, want %0d", lunar_day, want.day));
                if (leap_month_flag !== want.leap)
                    report_mismatch($sformatf("leap_month_flag %0d, want %0d",
                                              leap_month_flag, want.leap));
                case (want.status)
                    s2l_pkg::STAT_OK:     n_in_table++;
                    s2l_pkg::STAT_BEFORE: n_before++;
                    default:              n_beyond++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = s2l_pkg::OP_LOAD;
        table_index   = '0;
        table_word    = '0;
        solar_year    = '0;
        solar_month   = 4'd1;
        solar_day     = 5'd1;
        cfg_we        = 1'b0;
        cfg_index     = s2l_pkg::CFG_YEARS_IN_TABLE;
        cfg_data      = '0;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        years_cfg     = s2l_pkg::RST_YEARS_IN_TABLE;
        epoch_y_cfg   = s2l_pkg::RST_EPOCH_YEAR;
        epoch_m_cfg   = s2l_pkg::RST_EPOCH_MONTH;
        epoch_d_cfg   = s2l_pkg::RST_EPOCH_DAY;
        base_cfg      = s2l_pkg::RST_BASE_LUNAR_YEAR;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_fill();
        test_directed_dates();
        test_register_extremes();
        test_random_traffic();
        wait_idle();

        $display("Run covered %0d table loads and %0d conversions over %0d register settings",
                 n_loads, n_in_table + n_before + n_beyond, n_settings + 1);
        $display("Conversions: %0d inside the table, %0d before the epoch, %0d past the table end",
                 n_in_table, n_before, n_beyond);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
src/s2l_pkg.sv
src/s2l_ram.sv
src/s2l_ctrl.sv
src/s2l_dp.sv
src/solar_to_lunar_date_top.sv
verif/tb.sv
